// File: hdl/fust_pkg.sv
package fust_pkg;

	// symbol code width and alphabet size
	localparam int SYM_W   = 8;
	localparam int NUM_SYM = 1 << SYM_W;

	// per-symbol occurrence class
	typedef enum logic [1:0] {
		ST_UNSEEN   = 2'd0,
		ST_ONCE     = 2'd1,
		ST_REPEATED = 2'd2
	} status_t;

	// one write to the status memory
	typedef struct packed {
		logic             en;
		logic [SYM_W-1:0] addr;
		status_t          data;
	} stat_wr_t;

	// one write to a link memory
	typedef struct packed {
		logic             en;
		logic [SYM_W-1:0] addr;
		logic [SYM_W-1:0] data;
	} link_wr_t;

endpackage

// File: hdl/first_unique_symbol_tracker.sv
// channel  | handshake          | payload
// ---------+--------------------+---------------------
// input    | in_valid/in_ready  | restart, symbol
// output   | out_valid/out_ready| found, first_unique
//
// one item per cycle sustained while results are taken; each item reads its status and both links in
// the cycle it is accepted and writes them back when it leaves the update stage (one read and one write
// port per memory); the result is registered at that write
// reset clears the valid bits, list ends and valid flags but not the memories, so items are taken right away
// a held result stalls the update stage, which then stalls the input
module first_unique_symbol_tracker
	import fust_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       restart,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       found,
	output logic [7:0] first_unique
);

	// memories: status plus the two link directions of the once-seen list
	status_t          stat_mem [NUM_SYM];
	logic [SYM_W-1:0] next_mem [NUM_SYM];
	logic [SYM_W-1:0] prev_mem [NUM_SYM];

	status_t          stat_rd_q;
	logic [SYM_W-1:0] next_rd_q;
	logic [SYM_W-1:0] prev_rd_q;

	// writes done at the edge where the item in the update stage was read
	stat_wr_t stat_fwd_q;
	link_wr_t next_fwd_q;
	link_wr_t prev_fwd_q;

	// valid bits: a symbol without one reads as unseen
	logic [NUM_SYM-1:0] seen_q;

	// list ends
	logic             head_null_q;
	logic             tail_null_q;
	logic [SYM_W-1:0] head_q;
	logic [SYM_W-1:0] tail_q;

	// update stage
	logic             valid_s1;
	logic             restart_s1;
	logic [SYM_W-1:0] sym_s1;

	logic             in_acc;
	logic             adv;
	logic [SYM_W-1:0] in_sym;

	stat_wr_t stat_wr;
	link_wr_t next_wr;
	link_wr_t prev_wr;

	status_t          cur_stat;
	status_t          stat_val;
	logic [SYM_W-1:0] next_val;
	logic [SYM_W-1:0] prev_val;
	logic             hn_cur;
	logic             tn_cur;
	logic             hn_nxt;
	logic             tn_nxt;
	logic [SYM_W-1:0] head_nxt;
	logic [SYM_W-1:0] tail_nxt;
	logic [NUM_SYM-1:0] seen_nxt;
	logic             p_null;
	logic             n_null;

	// handshake
	assign adv      = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign in_acc   = in_valid && in_ready;
	assign in_sym   = SYM_W'(symbol);

	// status memory
	always_ff @(posedge clk) begin
		if (in_acc) begin
			stat_rd_q <= stat_mem[in_sym];
		end
		if (stat_wr.en) begin
			stat_mem[stat_wr.addr] <= stat_wr.data;
		end
	end

	// next link memory
	always_ff @(posedge clk) begin
		if (in_acc) begin
			next_rd_q <= next_mem[in_sym];
		end
		if (next_wr.en) begin
			next_mem[next_wr.addr] <= next_wr.data;
		end
	end

	// prev link memory
	always_ff @(posedge clk) begin
		if (in_acc) begin
			prev_rd_q <= prev_mem[in_sym];
		end
		if (prev_wr.en) begin
			prev_mem[prev_wr.addr] <= prev_wr.data;
		end
	end

	// forward a write that collided with this item's read
	always_comb begin
		stat_val = (stat_fwd_q.en && stat_fwd_q.addr == sym_s1) ? stat_fwd_q.data : stat_rd_q;
		next_val = (next_fwd_q.en && next_fwd_q.addr == sym_s1) ? next_fwd_q.data : next_rd_q;
		prev_val = (prev_fwd_q.en && prev_fwd_q.addr == sym_s1) ? prev_fwd_q.data : prev_rd_q;
	end

	// read-modify-write of the list for the item in the update stage
	always_comb begin
		hn_cur   = restart_s1 || head_null_q;
		tn_cur   = restart_s1 || tail_null_q;
		cur_stat = (!restart_s1 && seen_q[sym_s1]) ? stat_val : ST_UNSEEN;
		seen_nxt = restart_s1 ? '0 : seen_q;
		hn_nxt   = hn_cur;
		tn_nxt   = tn_cur;
		head_nxt = head_q;
		tail_nxt = tail_q;
		p_null   = !hn_cur && head_q == sym_s1;
		n_null   = !tn_cur && tail_q == sym_s1;
		stat_wr  = '{en: 1'b0, addr: sym_s1, data: ST_ONCE};
		next_wr  = '{en: 1'b0, addr: tail_q, data: sym_s1};
		prev_wr  = '{en: 1'b0, addr: sym_s1, data: tail_q};
		case (cur_stat)
			// append at the tail
			ST_UNSEEN: begin
				seen_nxt[sym_s1] = 1'b1;
				stat_wr.en       = adv;
				next_wr.en       = adv && !tn_cur;
				prev_wr.en       = adv && !tn_cur;
				if (tn_cur) begin
					hn_nxt   = 1'b0;
					head_nxt = sym_s1;
				end
				tn_nxt   = 1'b0;
				tail_nxt = sym_s1;
			end
			// unlink from its neighbors
			ST_ONCE: begin
				stat_wr.en   = adv;
				stat_wr.data = ST_REPEATED;
				next_wr.addr = prev_val;
				next_wr.data = next_val;
				next_wr.en   = adv && !p_null;
				prev_wr.addr = next_val;
				prev_wr.data = prev_val;
				prev_wr.en   = adv && !n_null;
				if (p_null) begin
					hn_nxt   = n_null;
					head_nxt = next_val;
				end
				if (n_null) begin
					tn_nxt   = p_null;
					tail_nxt = prev_val;
				end
			end
			// repeated symbols change nothing
			default: begin
				stat_wr.en = 1'b0;
			end
		endcase
	end

	// memory payload, update stage and result registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			stat_fwd_q <= stat_wr;
			next_fwd_q <= next_wr;
			prev_fwd_q <= prev_wr;
			restart_s1 <= restart;
			sym_s1     <= in_sym;
		end
		if (adv) begin
			head_q       <= head_nxt;
			tail_q       <= tail_nxt;
			found        <= !hn_nxt;
			first_unique <= hn_nxt ? 8'd0 : 8'(head_nxt);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid   <= 1'b0;
			seen_q      <= '0;
			head_null_q <= 1'b1;
			tail_null_q <= 1'b1;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid   <= 1'b1;
				seen_q      <= seen_nxt;
				head_null_q <= hn_nxt;
				tail_null_q <= tn_nxt;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// both list ends are empty together
	assert property (@(posedge clk) disable iff (!arst_n)
		head_null_q == tail_null_q)
		else $error("head and tail emptiness disagree");

	// the list head is always a symbol with a valid status
	assert property (@(posedge clk) disable iff (!arst_n)
		!head_null_q |-> seen_q[head_q])
		else $error("list head has no valid status");

	// the list tail is always a symbol with a valid status
	assert property (@(posedge clk) disable iff (!arst_n)
		!tail_null_q |-> seen_q[tail_q])
		else $error("list tail has no valid status");

	// a stalled update stage keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(sym_s1) && $stable(restart_s1))
		else $error("update stage lost its item while stalled");

	// an empty result carries a zero symbol
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> first_unique == 8'd0)
		else $error("empty result with nonzero symbol");
`endif

endmodule

// File: sim/first_unique_symbol_tracker_test.sv
module first_unique_symbol_tracker_test;
	import fust_pkg::*;

	localparam logic [SYM_W:0] NULL_IDX = (SYM_W + 1)'(NUM_SYM);
	localparam int TOTAL_ITEMS = 925;

	// one expected result item
	typedef struct packed {
		logic       found;
		logic [7:0] first_unique;
	} answer_t;

	// receiver stall patterns
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_EVERY_FOURTH,
		RX_MOSTLY
	} rx_mode_t;

	// tracks symbol history and the oldest once-seen symbol, checks results in order
	class unique_symbol_board;
		status_t        sym_state [NUM_SYM];
		logic [SYM_W:0] next_sym [NUM_SYM];
		logic [SYM_W:0] prev_sym [NUM_SYM];
		logic [SYM_W:0] oldest;
		logic [SYM_W:0] newest;
		answer_t        expected_answers [$];
		int             mismatch_count = 0;
		int             answer_count = 0;
		int             found_count = 0;
		int             restart_count = 0;
		int             unlink_count = 0;

		function new();
			clear_history();
		endfunction

		function void clear_history();
			foreach (sym_state[i])
				sym_state[i] = ST_UNSEEN;
			oldest = NULL_IDX;
			newest = NULL_IDX;
		endfunction

		// apply one accepted input item and queue the result it causes
		function void note_symbol(input logic rst, input logic [7:0] sym);
			logic [SYM_W-1:0] s;
			logic [SYM_W:0]   p;
			logic [SYM_W:0]   n;
			answer_t          a;
			s = sym[SYM_W-1:0];
			if (rst) begin
				clear_history();
				restart_count++;
			end
			case (sym_state[s])
				ST_UNSEEN: begin
					// append at the tail
					next_sym[s] = NULL_IDX;
					prev_sym[s] = newest;
					if (!newest[SYM_W])
						next_sym[newest[SYM_W-1:0]] = {1'b0, s};
					else
						oldest = {1'b0, s};
					newest = {1'b0, s};
					sym_state[s] = ST_ONCE;
				end
				ST_ONCE: begin
					// second occurrence: unlink from the list
					p = prev_sym[s];
					n = next_sym[s];
					if (!p[SYM_W])
						next_sym[p[SYM_W-1:0]] = n;
					else
						oldest = n;
					if (!n[SYM_W])
						prev_sym[n[SYM_W-1:0]] = p;
					else
						newest = p;
					sym_state[s] = ST_REPEATED;
					unlink_count++;
				end
				default: ;
			endcase
			a.found = !oldest[SYM_W];
			a.first_unique = a.found ? oldest[7:0] : 8'd0;
			expected_answers.push_back(a);
		endfunction

		// compare one accepted result item with the oldest expectation
		function void check_answer(input logic f, input logic [7:0] fu);
			answer_t want;
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual found=%0b first_unique=%0d",
					$time, f, fu);
				mismatch_count++;
				return;
			end
			want = expected_answers.pop_front();
			answer_count++;
			if (want.found)
				found_count++;
			if (f !== want.found) begin
				$display("%0t: found mismatch: expected %0b actual %0b", $time, want.found, f);
				mismatch_count++;
			end
			if (fu !== want.first_unique) begin
				$display("%0t: first_unique mismatch: expected %0d actual %0d",
					$time, want.first_unique, fu);
				mismatch_count++;
			end
		endfunction

		function int pending();
			return expected_answers.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       restart = 1'b0;
	logic [7:0] symbol = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       found;
	logic [7:0] first_unique;

	unique_symbol_board board;
	int items_sent = 0;
	int burst_left = 0;
	int holds_done = 0;
	bit hold_request = 1'b0;

	first_unique_symbol_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.symbol       (symbol),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.first_unique (first_unique)
	);

	// clock
	always #4 clk = ~clk;

	// run limit
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_answer(found, first_unique);
	end

	// receiver: stall patterns in phases, plus long hold-offs on request
	initial begin
		rx_mode_t mode;
		int       phase_left;
		int       tick;
		int       hold_left;
		mode = RX_OPEN;
		phase_left = 0;
		tick = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 250;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					phase_left = $urandom_range(20, 200);
				end
				phase_left--;
				tick++;
				case (mode)
					RX_OPEN:         out_ready <= 1'b1;
					RX_COIN:         out_ready <= 1'($urandom_range(0, 1));
					RX_EVERY_FOURTH: out_ready <= (tick % 4 == 0);
					default:         out_ready <= (tick % 5 != 0);
				endcase
			end
		end
	end

	// offer one item and hold it until accepted; bursts end in random gaps
	task send_item(input logic rst, input logic [7:0] sym);
		int gap;
		in_valid <= 1'b1;
		restart <= rst;
		symbol <= sym;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_symbol(rst, sym);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
		end
	endtask

	// wait until every expected result has come back (callers drop in_valid first)
	task drain_results();
		do
			@(posedge clk);
		while (board.pending() != 0);
	endtask

	// a run of symbols drawn from a small pool (or the full alphabet for big pools)
	task send_segment(input int count, input int pool_size, input bit lead_restart);
		logic [7:0] pool_syms [0:15];
		logic [7:0] sym;
		logic       rst;
		for (int i = 0; i < 16; i++)
			pool_syms[i] = 8'($urandom_range(0, 255));
		for (int k = 0; k < count; k++) begin
			if (pool_size >= 16)
				sym = 8'($urandom_range(0, 255));
			else
				sym = pool_syms[4'($urandom_range(0, pool_size - 1))];
			rst = (k == 0 && lead_restart) || ($urandom_range(0, 99) == 0);
			send_item(rst, sym);
		end
	endtask

	// a long list of distinct symbols, then repeats picked from it
	task send_fill_and_unlink(input int count);
		logic [7:0] base;
		logic [7:0] sym;
		base = 8'($urandom_range(0, 255));
		for (int k = 0; k < count; k++) begin
			sym = base + k[7:0];
			send_item(k == 0, sym);
		end
		for (int k = 0; k < count; k++) begin
			sym = 8'(base + $urandom_range(0, count - 1));
			send_item(1'b0, sym);
		end
	endtask

	// main stimulus
	initial begin
		bit hold_one;
		bit hold_two;
		bit drained;
		hold_one = 1'b0;
		hold_two = 1'b0;
		drained = 1'b0;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, head/middle/tail unlink, repeats, restarts
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hff);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hff);
		send_item(1'b0, 8'hff);
		send_item(1'b0, 8'h00);
		send_item(1'b1, 8'hff);
		send_item(1'b0, 8'h80);
		send_item(1'b0, 8'h7f);
		send_item(1'b0, 8'h80);
		send_item(1'b0, 8'h7f);
		send_item(1'b0, 8'h55);
		send_item(1'b0, 8'haa);
		send_item(1'b0, 8'hff);
		send_item(1'b1, 8'h55);
		send_item(1'b1, 8'h55);
		send_item(1'b0, 8'h55);
		send_item(1'b1, 8'h00);
		send_item(1'b0, 8'h01);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h01);
		send_item(1'b1, 8'haa);
		in_valid <= 1'b0;
		drain_results();

		// random segments
		while (items_sent < TOTAL_ITEMS) begin
			if (!hold_one && items_sent >= 300) begin
				hold_one = 1'b1;
				hold_request = 1'b1;
			end
			if (!hold_two && items_sent >= 650) begin
				hold_two = 1'b1;
				hold_request = 1'b1;
			end
			if (!drained && items_sent >= 480) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				drain_results();
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: send_segment($urandom_range(5, 40), $urandom_range(1, 15), 1'b1);
				6, 7:             send_segment($urandom_range(20, 120), 256, 1'b1);
				8:                send_segment($urandom_range(3, 20), $urandom_range(1, 15), 1'b0);
				default:          send_fill_and_unlink($urandom_range(2, 40));
			endcase
		end
		in_valid <= 1'b0;

		drain_results();
		repeat (16) @(posedge clk);

		$display("run covered %0d items, %0d results checked, %0d with a once-seen symbol",
			items_sent, board.answer_count, board.found_count);
		$display("%0d restarts, %0d unlinks, %0d long receiver hold-offs",
			board.restart_count, board.unlink_count, holds_done);
		if (board.mismatch_count == 0 && board.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: first_unique_symbol_tracker.f
hdl/fust_pkg.sv
hdl/first_unique_symbol_tracker.sv
sim/first_unique_symbol_tracker_test.sv
